// ===== rtl/ppid_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ppid_pkg;

    // register file addressing: word index sits in paddr[4:2]
    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;

    typedef logic [ADDR_W-1:0] t_addr;

    typedef enum logic [IDX_W-1:0] {
        REG_GAIN_P         = 3'd0,
        REG_GAIN_I         = 3'd1,
        REG_GAIN_D         = 3'd2,
        REG_DEAD_ZONE      = 3'd3,
        REG_INTEGRAL_LIMIT = 3'd4,
        REG_I_TERM_LIMIT   = 3'd5,
        REG_DRIVE_LIMIT    = 3'd6
    } t_reg_idx;

    // reset values of the limit registers
    localparam logic [23:0] INTEGRAL_LIMIT_RST = 24'hFF_FFFF;
    localparam logic [14:0] I_TERM_LIMIT_RST   = 15'h7FFF;
    localparam logic [14:0] DRIVE_LIMIT_RST    = 15'h7FFF;

    // controller settings as seen by the datapath
    typedef struct packed {
        logic [15:0] gain_p;
        logic [15:0] gain_i;
        logic [15:0] gain_d;
        logic [15:0] dead_zone;
        logic [23:0] integral_limit;
        logic [14:0] i_term_limit;
        logic [14:0] drive_limit;
    } t_cfg;

    // per-stage load strobes
    typedef struct packed {
        logic ld0;
        logic ld1;
        logic ld2;
        logic ld3;
    } t_pipe_ctl;

endpackage

`default_nettype wire

// ===== rtl/ppid_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ppid_dp (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  ppid_pkg::t_pipe_ctl    i_ctl,
    input  ppid_pkg::t_cfg         i_cfg,
    input  wire signed [15:0]      i_setpoint,
    input  wire signed [15:0]      i_measured,
    output logic signed [15:0]     o_drive
);
    import ppid_pkg::*;

    // input stage
    logic signed [15:0] r_sp;
    logic signed [15:0] r_ms;

    // controller state
    logic signed [24:0] r_esum;
    logic signed [16:0] r_prev;

    // error stage
    logic signed [16:0] r_e1;
    logic signed [24:0] r_s1;
    logic signed [17:0] r_d1;

    // product stage
    logic signed [32:0] r_pp;
    logic signed [40:0] r_pi;
    logic signed [33:0] r_pd;

    // result register
    logic signed [15:0] r_drive;

    logic signed [16:0] w_err_raw;
    logic signed [17:0] w_err18;
    logic signed [17:0] w_dz18;
    logic               w_in_band;
    logic signed [16:0] w_err;
    logic signed [25:0] w_sum26;
    logic signed [25:0] w_ilim26;
    logic signed [24:0] n_esum;
    logic signed [17:0] w_diff;

    logic signed [15:0] w_gp;
    logic signed [15:0] w_gi;
    logic signed [15:0] w_gd;

    logic signed [24:0] w_p;
    logic signed [32:0] w_i;
    logic signed [25:0] w_d;
    logic signed [32:0] w_itl;
    logic signed [15:0] w_ic;
    logic signed [27:0] w_sum28;
    logic signed [27:0] w_dlim28;
    logic signed [15:0] n_drive;

    assign w_gp = i_cfg.gain_p;
    assign w_gi = i_cfg.gain_i;
    assign w_gd = i_cfg.gain_d;

    // capture the input word
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld0) begin
            r_sp <= i_setpoint;
            r_ms <= i_measured;
        end
    end

    // error, deadband, integral update and error change
    always_comb begin
        w_err_raw = {r_sp[15], r_sp} - {r_ms[15], r_ms};
        w_err18   = {w_err_raw[16], w_err_raw};
        w_dz18    = {2'b00, i_cfg.dead_zone};
        w_in_band = (w_err18 > -w_dz18) && (w_err18 < w_dz18);
        w_err     = w_in_band ? 17'sd0 : w_err_raw;

        w_sum26   = {r_esum[24], r_esum} + {{9{w_err[16]}}, w_err};
        w_ilim26  = {2'b00, i_cfg.integral_limit};
        if (w_sum26 > w_ilim26) begin
            n_esum = w_ilim26[24:0];
        end else if (w_sum26 < -w_ilim26) begin
            n_esum = 25'(-w_ilim26);
        end else begin
            n_esum = w_sum26[24:0];
        end

        w_diff = {w_err[16], w_err} - {r_prev[16], r_prev};
    end

    // controller state, updated once per word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esum <= '0;
            r_prev <= '0;
        end else if (i_ctl.ld1) begin
            r_esum <= n_esum;
            r_prev <= w_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_e1 <= w_err;
            r_s1 <= n_esum;
            r_d1 <= w_diff;
        end
    end

    // gain products, all exact
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_pp <= 33'(w_gp) * 33'(r_e1);
            r_pi <= 41'(w_gi) * 41'(r_s1);
            r_pd <= 34'(w_gd) * 34'(r_d1);
        end
    end

    // floor shift by 8, i term clamp, sum and drive clamp
    always_comb begin
        w_p   = r_pp[32:8];
        w_i   = r_pi[40:8];
        w_d   = r_pd[33:8];

        w_itl = {18'b0, i_cfg.i_term_limit};
        if (w_i > w_itl) begin
            w_ic = w_itl[15:0];
        end else if (w_i < -w_itl) begin
            w_ic = 16'(-w_itl);
        end else begin
            w_ic = w_i[15:0];
        end

        w_sum28  = {{3{w_p[24]}}, w_p} + {{2{w_d[25]}}, w_d} + {{12{w_ic[15]}}, w_ic};
        w_dlim28 = {13'b0, i_cfg.drive_limit};
        if (w_sum28 > w_dlim28) begin
            n_drive = w_dlim28[15:0];
        end else if (w_sum28 < -w_dlim28) begin
            n_drive = 16'(-w_dlim28);
        end else begin
            n_drive = w_sum28[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            r_drive <= n_drive;
        end
    end

    assign o_drive = r_drive;

endmodule

`default_nettype wire

// ===== rtl/positional_pid_deadband_clamped_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Positional PID step with an error deadband. Each input word carries a
// setpoint and a measured value; one drive word comes out for each, in order.
// Throughput is one word per clock unless the result side stalls; a drive word
// passes from the input register through the error stage, product stage and
// result register. The integral and last-error state close their loop within
// the error stage, so consecutive words need no gap. Each stage holds its word
// while the next one is full and not moving, so input is still taken while a
// result waits, until all four stages hold a word. Gains are signed Q8.8;
// products are shifted right by 8 with floor rounding. The user must write
// registers over the APB port only while no word is in flight (not enforced).

module positional_pid_deadband_clamped_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,

    // input stream
    input  wire                 s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire [31:0]          s_axis_tdata,   // [15:0] setpoint, [31:16] measured

    // result stream
    output logic                m_axis_tvalid,
    input  wire                 m_axis_tready,
    output logic [15:0]         m_axis_tdata,   // [15:0] drive

    // register port
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  ppid_pkg::t_addr     paddr,
    input  wire [31:0]          pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import ppid_pkg::*;

    logic [15:0] r_gain_p;
    logic [15:0] r_gain_i;
    logic [15:0] r_gain_d;
    logic [15:0] r_dead_zone;
    logic [23:0] r_integral_limit;
    logic [14:0] r_i_term_limit;
    logic [14:0] r_drive_limit;

    logic        w_wr;
    t_reg_idx    w_idx;
    t_cfg        w_cfg;

    logic        r_v0;
    logic        r_v1;
    logic        r_v2;
    logic        r_ov;
    logic        w_en0;
    logic        w_en1;
    logic        w_en2;
    logic        w_en3;
    t_pipe_ctl   w_ctl;

    logic signed [15:0] w_drive;

    // register file
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p         <= '0;
            r_gain_i         <= '0;
            r_gain_d         <= '0;
            r_dead_zone      <= '0;
            r_integral_limit <= INTEGRAL_LIMIT_RST;
            r_i_term_limit   <= I_TERM_LIMIT_RST;
            r_drive_limit    <= DRIVE_LIMIT_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_GAIN_P:         r_gain_p         <= pwdata[15:0];
                REG_GAIN_I:         r_gain_i         <= pwdata[15:0];
                REG_GAIN_D:         r_gain_d         <= pwdata[15:0];
                REG_DEAD_ZONE:      r_dead_zone      <= pwdata[15:0];
                REG_INTEGRAL_LIMIT: r_integral_limit <= pwdata[23:0];
                REG_I_TERM_LIMIT:   r_i_term_limit   <= pwdata[14:0];
                REG_DRIVE_LIMIT:    r_drive_limit    <= pwdata[14:0];
                default: begin
                end
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (w_idx)
            REG_GAIN_P:         prdata = {16'b0, r_gain_p};
            REG_GAIN_I:         prdata = {16'b0, r_gain_i};
            REG_GAIN_D:         prdata = {16'b0, r_gain_d};
            REG_DEAD_ZONE:      prdata = {16'b0, r_dead_zone};
            REG_INTEGRAL_LIMIT: prdata = {8'b0, r_integral_limit};
            REG_I_TERM_LIMIT:   prdata = {17'b0, r_i_term_limit};
            REG_DRIVE_LIMIT:    prdata = {17'b0, r_drive_limit};
            default:            prdata = '0;
        endcase
    end

    assign w_cfg = '{
        gain_p:         r_gain_p,
        gain_i:         r_gain_i,
        gain_d:         r_gain_d,
        dead_zone:      r_dead_zone,
        integral_limit: r_integral_limit,
        i_term_limit:   r_i_term_limit,
        drive_limit:    r_drive_limit
    };

    // stage advance: a stage moves when the one after it is empty or moving
    assign w_en3 = !r_ov || m_axis_tready;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign w_en0 = !r_v0 || w_en1;

    assign w_ctl.ld0 = s_axis_tvalid && w_en0;
    assign w_ctl.ld1 = r_v0 && w_en1;
    assign w_ctl.ld2 = r_v1 && w_en2;
    assign w_ctl.ld3 = r_v2 && w_en3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_en0) begin
                r_v0 <= s_axis_tvalid;
            end
            if (w_en1) begin
                r_v1 <= r_v0;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_ov <= r_v2;
            end
        end
    end

    assign s_axis_tready = w_en0;
    assign m_axis_tvalid = r_ov;

    // controller datapath
    ppid_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_cfg      (w_cfg),
        .i_setpoint (s_axis_tdata[15:0]),
        .i_measured (s_axis_tdata[31:16]),
        .o_drive    (w_drive)
    );

    assign m_axis_tdata = w_drive;

endmodule

`default_nettype wire

// ===== rtl/ppid_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ppid_chk (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 s_axis_tready,
    input  wire                 m_axis_tvalid,
    input  wire                 m_axis_tready,
    input  wire [15:0]          m_axis_tdata,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  ppid_pkg::t_addr     paddr,
    input  wire [31:0]          pwdata,
    input  wire [31:0]          prdata,
    input  wire                 pready
);
    import ppid_pkg::*;

    logic [14:0] r_lim;
    logic [16:0] w_mag;
    logic        w_wr;
    logic        w_wr_gp;

    assign w_wr    = psel && penable && pwrite && pready;
    assign w_wr_gp = w_wr && (paddr[ADDR_W-1:2] == REG_GAIN_P);

    // shadow of the drive limit as written on the port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= DRIVE_LIMIT_RST;
        end else if (w_wr && (paddr[ADDR_W-1:2] == REG_DRIVE_LIMIT)) begin
            r_lim <= pwdata[14:0];
        end
    end

    // magnitude of the drive word
    assign w_mag = m_axis_tdata[15] ? (17'd0 - {1'b1, m_axis_tdata}) : {1'b0, m_axis_tdata};

    // no result right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

    // drive stays within the programmed limit
    a_drive_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_mag <= {2'b00, r_lim}))
        else $error("drive outside limit");

    // with the result register empty the input side is open
    a_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty result register");

    // gain write reads back
    a_gain_rb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_gp ##1 (psel && !pwrite && (paddr[ADDR_W-1:2] == REG_GAIN_P))
        |-> prdata[15:0] == $past(pwdata[15:0]))
        else $error("gain readback mismatch");

endmodule

bind positional_pid_deadband_clamped_core ppid_chk u_ppid_chk (.*);

`default_nettype wire

// ===== verif/tb_positional_pid_deadband_clamped_core.sv =====
`timescale 1ns / 1ps

module tb_positional_pid_deadband_clamped_core;

    import ppid_pkg::*;

    // register beyond the map, writes to it must be dropped
    localparam logic [2:0] REG_UNMAPPED = 3'd7;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_PHASES = 11;
    localparam int WORDS_PER_PHASE = 103;
    localparam int DRAIN_CYCLES = 12;

    logic i_clk;
    logic i_rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // [15:0] setpoint, [31:16] measured

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [15:0] drive

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    t_addr       paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    positional_pid_deadband_clamped_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // controller settings mirrored on the testbench side
    logic signed [15:0] k_p = '0;
    logic signed [15:0] k_i = '0;
    logic signed [15:0] k_d = '0;
    logic [15:0]        band = '0;
    logic [23:0]        integ_lim = INTEGRAL_LIMIT_RST;
    logic [14:0]        iterm_lim = I_TERM_LIMIT_RST;
    logic [14:0]        drive_lim = DRIVE_LIMIT_RST;

    // controller state mirror
    logic signed [24:0] integ_acc = '0;
    logic signed [16:0] prev_err = '0;

    logic [15:0] drive_q[$];
    logic [15:0] drive_exp;
    int          err_count = 0;
    int          burst_left = 0;
    bit          gaps_on = 1'b1;
    int          stall_cyc = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic signed [47:0] clamp_sym(input logic signed [47:0] v,
                                                     input logic [23:0] lim);
        logic signed [47:0] bound;
        bound = $signed({24'd0, lim});
        if (v > bound) return bound;
        if (v < -bound) return -bound;
        return v;
    endfunction

    // one controller step: updates the mirrored state, returns the drive word
    function automatic logic [15:0] predict_drive(input logic signed [15:0] sp,
                                                  input logic signed [15:0] ms);
        logic signed [16:0] err;
        logic signed [17:0] band_s;
        logic signed [47:0] acc_wide;
        logic signed [47:0] p_prod, i_prod, d_prod;
        logic signed [47:0] p_term, i_term, d_term, total;
        band_s = $signed({2'b00, band});
        err = sp - ms;
        // deadband, strict on both sides
        if (err > -band_s && err < band_s) err = '0;
        acc_wide = integ_acc + err;
        acc_wide = clamp_sym(acc_wide, integ_lim);
        integ_acc = acc_wide[24:0];
        p_prod = k_p * err;
        i_prod = k_i * integ_acc;
        d_prod = k_d * (err - prev_err);
        p_term = p_prod >>> 8;
        i_term = clamp_sym(i_prod >>> 8, {9'd0, iterm_lim});
        d_term = d_prod >>> 8;
        total = clamp_sym(p_term + i_term + d_term, {9'd0, drive_lim});
        prev_err = err;
        return total[15:0];
    endfunction

    task automatic flag_error(input string msg);
        if (err_count < MAX_REPORTS) $display("ERROR: %s", msg);
        err_count++;
    endtask

    // let the pipeline empty before touching registers
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (drive_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // register write over the apb port, upper bits of pwdata are junk
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= t_addr'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_GAIN_P:         k_p = value[15:0];
            REG_GAIN_I:         k_i = value[15:0];
            REG_GAIN_D:         k_d = value[15:0];
            REG_DEAD_ZONE:      band = value[15:0];
            REG_INTEGRAL_LIMIT: integ_lim = value[23:0];
            REG_I_TERM_LIMIT:   iterm_lim = value[14:0];
            REG_DRIVE_LIMIT:    drive_lim = value[14:0];
            default: ;
        endcase
    endtask

    // send one sample word, bursts with random gaps in between
    task automatic send_word(input logic [15:0] sp, input logic [15:0] ms);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ms, sp};
        do @(posedge i_clk); while (!s_axis_tready);
        drive_q.push_back(predict_drive(sp, ms));
    endtask

    // result checker and receiver stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (drive_q.size() == 0) begin
                flag_error($sformatf("unexpected drive word %h", m_axis_tdata));
            end else begin
                drive_exp = drive_q.pop_front();
                if (m_axis_tdata !== drive_exp)
                    flag_error($sformatf("drive expected %h actual %h",
                                         drive_exp, m_axis_tdata));
            end
        end
        stall_cyc++;
        case ((stall_cyc / 97) % 4)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= (stall_cyc % 8) != 0;
            2: m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ((stall_cyc / 8) % 4) == 0;
        endcase
    end

    // zero gains after reset give zero drive
    task automatic test_reset_state();
        send_word(16'h7FFF, 16'h8000);
        send_word(16'h1234, 16'hFEDC);
    endtask

    // gain and error extremes, output and integral saturation
    task automatic test_gain_extremes();
        write_reg(REG_GAIN_P, 32'hA5A5_7FFF);
        write_reg(REG_GAIN_I, 32'h0000_8000);
        write_reg(REG_GAIN_D, 32'hFFFF_7FFF);
        send_word(16'h7FFF, 16'h8000);
        send_word(16'h8000, 16'h7FFF);
        send_word(16'h0000, 16'h0000);
        send_word(16'h8000, 16'h8000);
        write_reg(REG_GAIN_P, 32'h0000_8000);
        write_reg(REG_GAIN_D, 32'h0000_0100);
        send_word(16'h7FFF, 16'h8000);
        send_word(16'h0001, 16'h0000);
    endtask

    // strict deadband edges, zero and full width
    task automatic test_deadband();
        write_reg(REG_DEAD_ZONE, 32'hFFFF_0064);
        send_word(16'd99, 16'd0);
        send_word(16'd100, 16'd0);
        send_word(16'h0000, 16'd99);
        send_word(16'h0000, 16'd100);
        write_reg(REG_DEAD_ZONE, 32'h0000_FFFF);
        send_word(16'h7FFF, 16'h8000);
        send_word(16'h8000, 16'h7FFF);
        send_word(16'h7FFF, 16'h8001);
        write_reg(REG_DEAD_ZONE, 32'h0000_0000);
        send_word(16'h0000, 16'h0001);
    endtask

    // every limit at zero, then back to full scale
    task automatic test_zero_limits();
        write_reg(REG_INTEGRAL_LIMIT, 32'hFF00_0000);
        write_reg(REG_I_TERM_LIMIT, 32'hFFFF_8000);
        send_word(16'h4000, 16'hC000);
        write_reg(REG_DRIVE_LIMIT, 32'h0000_8000);
        send_word(16'h7FFF, 16'h8000);
        write_reg(REG_INTEGRAL_LIMIT, 32'h00FF_FFFF);
        write_reg(REG_I_TERM_LIMIT, 32'h0000_7FFF);
        write_reg(REG_DRIVE_LIMIT, 32'h0000_7FFF);
        send_word(16'h7FFF, 16'h8000);
    endtask

    // write past the register map must change nothing
    task automatic test_unmapped_index();
        write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
        send_word(16'h2000, 16'hE000);
        send_word(16'hF000, 16'h1000);
    endtask

    function automatic logic [15:0] rand_gain();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 1023) - 512);
            3: return 16'($urandom_range(0, 8191) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] rand_limit(input logic [23:0] full);
        case ($urandom_range(0, 5))
            0: return full;
            1: return 24'd0;
            2: return 24'($urandom_range(0, 255)) & full;
            default: return 24'($urandom) & full;
        endcase
    endfunction

    // random settings per phase, samples near and far from the deadband
    task automatic test_random();
        logic [15:0] sp, ms;
        int off;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            gaps_on = (ph % 4) != 1;
            write_reg(REG_GAIN_P, {16'($urandom), rand_gain()});
            write_reg(REG_GAIN_I, {16'($urandom), rand_gain()});
            write_reg(REG_GAIN_D, {16'($urandom), rand_gain()});
            case ($urandom_range(0, 4))
                0: write_reg(REG_DEAD_ZONE, {16'($urandom), 16'd0});
                1: write_reg(REG_DEAD_ZONE, {16'($urandom), 16'hFFFF});
                2: write_reg(REG_DEAD_ZONE, {16'($urandom), 16'($urandom)});
                default: write_reg(REG_DEAD_ZONE,
                                   {16'($urandom), 16'($urandom_range(0, 600))});
            endcase
            write_reg(REG_INTEGRAL_LIMIT, {8'($urandom), rand_limit(24'hFF_FFFF)});
            write_reg(REG_I_TERM_LIMIT, {17'($urandom), 15'(rand_limit(24'h7FFF))});
            write_reg(REG_DRIVE_LIMIT, {17'($urandom), 15'(rand_limit(24'h7FFF))});
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                sp = 16'($urandom);
                case ($urandom_range(0, 9))
                    6, 7, 8: begin
                        off = $urandom_range(0, 2 * band + 4) - (band + 2);
                        ms = 16'(int'($signed(sp)) - off);
                    end
                    9: begin
                        sp = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                        ms = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                    end
                    default: ms = 16'($urandom);
                endcase
                send_word(sp, ms);
            end
        end
    endtask

    // main sequence
    initial begin
        int waited;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_gain_extremes();
        test_deadband();
        test_zero_limits();
        test_unmapped_index();
        test_random();
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (drive_q.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && drive_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

endmodule
